[rtl/ssa_pkg.sv]
// Shared types, constants and codes for the segment sum accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ssa_pkg;

   localparam int MAX_SEGMENTS   = 64;
   localparam int MAX_ROW_LENGTH = 256;
   localparam int STORE_DEPTH    = MAX_SEGMENTS * MAX_ROW_LENGTH;

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   localparam int FUNC_W     = 2;
   localparam int ID_W       = 16;
   localparam int POS_W      = 8;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int SEGCNT_W   = 7;
   localparam int ROWLEN_W   = 9;
   localparam int ROWCMP_W   = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 40;

   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SORTED_MODE   = 2'd2;

   localparam logic [VALUE_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] SUM_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_JOB_CLEAR,
      ST_EXEC
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic mem_read;
      logic clear_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_start;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

[rtl/ssa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the accumulator store; depends on nothing.
`default_nettype none

module ssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ssa_ctrl.sv]
// Controller state machine: clearing sweeps, item intake, memory read and commit.
// Depends on ssa_pkg for the state, command and status types.
`default_nettype none

module ssa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ssa_pkg::stat_type stat,
   output ssa_pkg::cmd_type  cmd
);
   import ssa_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      case (state_ff)
         ST_INIT_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = stat.is_start ? ST_JOB_CLEAR : ST_EXEC;
         end
         ST_JOB_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/ssa_datapath.sv]
// Datapath: configuration registers, segment tracking, accumulator store,
// saturating adder and the result register. Depends on ssa_pkg and ssa_ram.
`default_nettype none

module ssa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ssa_pkg::cmd_type                   cmd,
   output ssa_pkg::stat_type                  stat,
   input  logic                               csr_wr_en,
   input  logic [ssa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ssa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [ssa_pkg::FUNC_W-1:0]         req_tuser,
   input  logic [ssa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [ssa_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import ssa_pkg::*;

   logic [SEGCNT_W-1:0] seg_count_ff, seg_count_in;
   logic [ROWLEN_W-1:0] row_len_ff, row_len_in;
   logic                sorted_ff, sorted_in;
   logic [SEG_W-1:0]    cur_seg_ff, cur_seg_in;
   logic                halted_ff, halted_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic                is_start_ff, is_start_in;
   logic                op_add_ff, op_add_in;
   logic                op_read_ff, op_read_in;
   logic                drop_ff, drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [FUNC_W-1:0]   req_func;
   logic [ID_W-1:0]     req_id;
   logic [POS_W-1:0]    req_pos;
   logic [ID_W-1:0]     id_mag;
   logic [ID_W-1:0]     seg_lim;
   logic [ROWCMP_W-1:0] row_lim;
   logic                id_valid;
   logic                pos_ok;
   logic                id_ge_cur;
   logic [SEG_W-1:0]    id_seg;

   logic [VALUE_W-1:0]  rd_data;
   logic [VALUE_W:0]    wide_sum;
   logic                sum_ovf;
   logic [VALUE_W-1:0]  sat_sum;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [VALUE_W-1:0]  ram_wr_data;

   assign req_func = req_tuser;
   assign req_id   = req_tdata[ID_W-1:0];
   assign req_pos  = req_tdata[ID_W+POS_W-1:ID_W];
   assign id_mag   = {1'b0, req_id[ID_W-2:0]};
   assign id_seg   = req_id[SEG_W-1:0];

   assign seg_lim = (ID_W'(seg_count_ff) < ID_W'(MAX_SEGMENTS)) ?
                    ID_W'(seg_count_ff) : ID_W'(MAX_SEGMENTS);
   assign row_lim = (ROWCMP_W'(row_len_ff) < ROWCMP_W'(MAX_ROW_LENGTH)) ?
                    ROWCMP_W'(row_len_ff) : ROWCMP_W'(MAX_ROW_LENGTH);

   assign id_valid  = !req_id[ID_W-1] && (id_mag < seg_lim);
   assign pos_ok    = ROWCMP_W'(req_pos) < row_lim;
   assign id_ge_cur = id_mag >= ID_W'(cur_seg_ff);

   assign wide_sum = {rd_data[VALUE_W-1], rd_data} + {val_ff[VALUE_W-1], val_ff};
   assign sum_ovf  = wide_sum[VALUE_W] ^ wide_sum[VALUE_W-1];
   assign sat_sum  = sum_ovf ? (wide_sum[VALUE_W] ? SUM_MIN : SUM_MAX)
                             : wide_sum[VALUE_W-1:0];

   always_comb begin
      seg_count_in  = seg_count_ff;
      row_len_in    = row_len_ff;
      sorted_in     = sorted_ff;
      cur_seg_in    = cur_seg_ff;
      halted_in     = halted_ff;
      clr_addr_in   = clr_addr_ff;
      addr_in       = addr_ff;
      val_in        = val_ff;
      is_start_in   = is_start_ff;
      op_add_in     = op_add_ff;
      op_read_in    = op_read_ff;
      drop_in       = drop_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_SEGMENT_COUNT: seg_count_in = csr_wdata[SEGCNT_W-1:0];
            CSR_ROW_LENGTH:    row_len_in   = csr_wdata[ROWLEN_W-1:0];
            CSR_SORTED_MODE:   sorted_in    = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         is_start_in = (req_func == FUNC_START);
         op_add_in   = 1'b0;
         op_read_in  = 1'b0;
         drop_in     = 1'b0;
         addr_in     = ADDR_W'(id_seg) * ADDR_W'(MAX_ROW_LENGTH) + ADDR_W'(req_pos);
         val_in      = req_tdata[ID_W+POS_W+VALUE_W-1:ID_W+POS_W];
         case (req_func)
            FUNC_START: begin
               cur_seg_in = '0;
               halted_in  = 1'b0;
            end
            FUNC_ADD: begin
               if (halted_ff || !pos_ok) begin
                  drop_in = 1'b1;
               end else if (!sorted_ff) begin
                  op_add_in = id_valid;
                  drop_in   = !id_valid;
               end else if (id_valid && id_ge_cur) begin
                  cur_seg_in = id_seg;
                  op_add_in  = 1'b1;
               end else begin
                  halted_in = 1'b1;
                  drop_in   = 1'b1;
               end
            end
            FUNC_READ: begin
               op_read_in = id_valid && pos_ok;
               drop_in    = !(id_valid && pos_ok);
            end
            default: begin
               drop_in = 1'b1;
            end
         endcase
      end

      if (cmd.clear_step) begin
         clr_addr_in = stat.clear_last ? '0 : clr_addr_ff + 1'b1;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = op_read_ff ? rd_data : '0;
         if (drop_ff) begin
            rsp_status_in = STATUS_DROP;
         end else if (op_add_ff && sum_ovf) begin
            rsp_status_in = STATUS_SAT;
         end else begin
            rsp_status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEGCNT_W'(64);
         row_len_ff   <= ROWLEN_W'(256);
         sorted_ff    <= 1'b0;
         cur_seg_ff   <= '0;
         halted_ff    <= 1'b0;
         clr_addr_ff  <= '0;
         is_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_count_ff <= seg_count_in;
         row_len_ff   <= row_len_in;
         sorted_ff    <= sorted_in;
         cur_seg_ff   <= cur_seg_in;
         halted_ff    <= halted_in;
         clr_addr_ff  <= clr_addr_in;
         is_start_ff  <= is_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      val_ff        <= val_in;
      op_add_ff     <= op_add_in;
      op_read_ff    <= op_read_in;
      drop_ff       <= drop_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign ram_wr_en   = cmd.clear_step || (cmd.commit && op_add_ff);
   assign ram_wr_addr = cmd.clear_step ? clr_addr_ff : addr_ff;
   assign ram_wr_data = cmd.clear_step ? '0 : sat_sum;

   ssa_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign stat.clear_last = (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1));
   assign stat.is_start   = is_start_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - VALUE_W - STATUS_W)'(0), rsp_status_ff, rsp_sum_ff};

endmodule

`default_nettype wire

[rtl/segment_sum_accumulator.sv]
// Segment sum accumulator top level: controller plus datapath.
// An accepted item is read from the store, then committed once the result register is
// free; no new item is accepted until then. A start item also sweeps the 16384-word
// accumulator store, one word per cycle, before its result is committed.
// Reset is synchronous; after reset the same sweep of the store runs before the
// first item is accepted. Configuration writes are taken at any time.
`default_nettype none

module segment_sum_accumulator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ssa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ssa_pkg::REQ_TDATA_W-1:0] req_tdata,  // segment_id, position, value_in
   input  logic [ssa_pkg::FUNC_W-1:0]      req_tuser,  // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ssa_pkg::RSP_TDATA_W-1:0] rsp_tdata   // sum_out, status
);
   import ssa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ssa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ssa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   a_no_clear_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && cmd.commit))
      else $error("store sweep and item commit in the same cycle");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.mem_read)
      else $error("accepted word not followed by a store read");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result committed over an untaken word");

endmodule

`default_nettype wire
